// ===== rtl/pscv_pkg.sv =====
`timescale 1ns / 1ps

package pscv_pkg;

    // Sample format codes, shared by both configuration registers.
    typedef logic [2:0] t_fmt;

    localparam t_fmt FMT_S8  = 3'd0;
    localparam t_fmt FMT_S16 = 3'd1;
    localparam t_fmt FMT_S24 = 3'd2;
    localparam t_fmt FMT_S32 = 3'd3;
    localparam t_fmt FMT_F32 = 3'd4;
    localparam t_fmt FMT_F64 = 3'd5;

    // Configuration register indexes.
    typedef logic t_cfg_idx;

    localparam t_cfg_idx CFG_SRC = 1'b0;
    localparam t_cfg_idx CFG_DST = 1'b1;

    // Unbiased binary exponent, wide enough for float64 subnormals.
    typedef logic signed [11:0] t_exp;

    // First stage: raw fields pulled apart.
    typedef struct packed {
        t_fmt        src;
        t_fmt        dst;
        logic [63:0] raw;
        logic [31:0] ival;
        logic [31:0] rval;
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic        is_sub;
        t_exp        exp;
        logic [52:0] sig;
    } t_unpk;

    // Second stage: every source as one normalized real.
    typedef struct packed {
        t_fmt        src;
        t_fmt        dst;
        logic [63:0] raw;
        logic [31:0] ival;
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        t_exp        exp;
        logic [52:0] sig;
    } t_norm;

    // Third stage: aligned magnitudes, ready for rounding and sign.
    typedef struct packed {
        t_fmt        dst;
        logic [31:0] ival;
        logic        from_float;
        logic        fsat;
        logic [30:0] fmag;
        logic        sign;
        logic        f32_spec;
        logic [31:0] f32_spec_bits;
        logic [30:0] f32_base;
        logic        f32_guard;
        logic        f32_sticky;
        logic [63:0] f64_bits;
    } t_algn;

    // Count of leading zeros in a 32-bit word; zero input gives zero.
    function automatic logic [4:0] lzc32(input logic [31:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 5'(31 - i);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/pscv_unpack.sv =====
`timescale 1ns / 1ps

module pscv_unpack (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [63:0]        i_sample,
    input  pscv_pkg::t_fmt     i_src,
    input  pscv_pkg::t_fmt     i_dst,
    output pscv_pkg::t_unpk    o_q
);
    import pscv_pkg::*;

    t_unpk       n_q;
    t_unpk       r_q;
    logic [31:0] rep8;
    logic [31:0] rep16;
    logic [31:0] rep24;

    // Left-align the integer sources and fill low bits by repeating magnitude bits.
    always_comb begin
        rep8  = {i_sample[7:0], 24'd0};
        rep8  = rep8 | ((rep8 & 32'h7F00_0000) >> 7);
        rep8  = rep8 | ((rep8 & 32'h7FFE_0000) >> 14);
        rep8  = rep8 | ((rep8 & 32'h7FFF_FFF8) >> 28);
        rep16 = {i_sample[15:0], 16'd0};
        rep16 = rep16 | ((rep16 & 32'h7FFF_0000) >> 15);
        rep16 = rep16 | ((rep16 & 32'h7FFF_FFFE) >> 30);
        rep24 = {i_sample[23:0], 8'd0};
        rep24 = rep24 | ((rep24 & 32'h7FFF_FF00) >> 23);
    end

    // Split the sample by source format.
    always_comb begin
        n_q     = '0;
        n_q.src = i_src;
        n_q.dst = i_dst;
        n_q.raw = i_sample;
        case (i_src)
            FMT_S8: begin
                n_q.ival = rep8;
                n_q.rval = {i_sample[7:0], 24'd0};
            end
            FMT_S16: begin
                n_q.ival = rep16;
                n_q.rval = {i_sample[15:0], 16'd0};
            end
            FMT_S24: begin
                n_q.ival = rep24;
                n_q.rval = rep24;
            end
            FMT_S32: begin
                n_q.ival = i_sample[31:0];
                n_q.rval = i_sample[31:0];
            end
            FMT_F32: begin
                n_q.sign    = i_sample[31];
                n_q.is_nan  = (i_sample[30:23] == 8'hFF) && (i_sample[22:0] != '0);
                n_q.is_inf  = (i_sample[30:23] == 8'hFF) && (i_sample[22:0] == '0);
                n_q.is_zero = (i_sample[30:23] == 8'h00) && (i_sample[22:0] == '0);
                n_q.is_sub  = (i_sample[30:23] == 8'h00) && (i_sample[22:0] != '0);
                n_q.exp     = t_exp'($signed({4'b0000, i_sample[30:23]}) - 12'sd127);
                if (n_q.is_nan) begin
                    // Quiet bit set, payload moved to the float64 position.
                    n_q.sig = {1'b0, 1'b1, i_sample[21:0], 29'd0};
                end else begin
                    n_q.sig = {1'b1, i_sample[22:0], 29'd0};
                end
            end
            FMT_F64: begin
                n_q.sign    = i_sample[63];
                n_q.is_nan  = (i_sample[62:52] == 11'h7FF) && (i_sample[51:0] != '0);
                n_q.is_inf  = (i_sample[62:52] == 11'h7FF) && (i_sample[51:0] == '0);
                n_q.is_zero = (i_sample[62:52] == 11'h000) && (i_sample[51:0] == '0);
                if (i_sample[62:52] == 11'h000) begin
                    // Subnormal values are far below every narrower range.
                    n_q.exp = -12'sd1074;
                    n_q.sig = {1'b0, i_sample[51:0]};
                end else begin
                    n_q.exp = t_exp'($signed({1'b0, i_sample[62:52]}) - 12'sd1023);
                    n_q.sig = {1'b1, i_sample[51:0]};
                end
            end
            default: begin
                n_q.is_zero = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/pscv_norm.sv =====
`timescale 1ns / 1ps

module pscv_norm (
    input  logic            i_clk,
    input  logic            i_en,
    input  pscv_pkg::t_unpk i_d,
    output pscv_pkg::t_norm o_q
);
    import pscv_pkg::*;

    t_norm       n_q;
    t_norm       r_q;
    logic [31:0] mag;
    logic [4:0]  lz_i;
    logic [4:0]  lz_s;

    // Integer sources become a normalized real; float32 subnormals get normalized.
    always_comb begin
        mag         = i_d.rval[31] ? (~i_d.rval + 32'd1) : i_d.rval;
        lz_i        = lzc32(mag);
        lz_s        = lzc32({i_d.sig[51:29], 9'd0});
        n_q.src     = i_d.src;
        n_q.dst     = i_d.dst;
        n_q.raw     = i_d.raw;
        n_q.ival    = i_d.ival;
        n_q.sign    = i_d.sign;
        n_q.is_nan  = i_d.is_nan;
        n_q.is_inf  = i_d.is_inf;
        n_q.is_zero = i_d.is_zero;
        n_q.exp     = i_d.exp;
        n_q.sig     = i_d.sig;
        case (i_d.src) inside
            FMT_S8, FMT_S16, FMT_S24, FMT_S32: begin
                n_q.sign    = i_d.rval[31];
                n_q.is_nan  = 1'b0;
                n_q.is_inf  = 1'b0;
                n_q.is_zero = (i_d.rval == '0);
                n_q.exp     = t_exp'(12'sd0 - $signed({7'd0, lz_i}));
                n_q.sig     = {mag << lz_i, 21'd0};
            end
            FMT_F32: begin
                if (i_d.is_sub) begin
                    n_q.exp = t_exp'(-12'sd127 - $signed({7'd0, lz_s}));
                    n_q.sig = {1'b0, i_d.sig[51:29], 29'd0} << ({1'b0, lz_s} + 6'd1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/pscv_align.sv =====
`timescale 1ns / 1ps

module pscv_align (
    input  logic            i_clk,
    input  logic            i_en,
    input  pscv_pkg::t_norm i_d,
    output pscv_pkg::t_algn o_q
);
    import pscv_pkg::*;

    t_algn       n_q;
    t_algn       r_q;
    t_exp        int_sh;
    t_exp        sub_sh;
    logic [52:0] int_shifted;
    logic [4:0]  f32_sh;
    logic [7:0]  f32_expf;
    logic [78:0] f32_wide;
    t_exp        f32_bexp;
    t_exp        f64_bexp;

    // Shift the significand for the integer and float32 results.
    always_comb begin
        int_sh      = t_exp'(12'sd21 - i_d.exp);
        int_shifted = i_d.sig >> int_sh[5:0];
        sub_sh      = t_exp'(-12'sd126 - i_d.exp);
        f32_bexp    = t_exp'(i_d.exp + 12'sd127);
        f64_bexp    = t_exp'(i_d.exp + 12'sd1023);
        if (i_d.exp >= -12'sd126) begin
            f32_sh   = 5'd0;
            f32_expf = f32_bexp[7:0];
        end else begin
            f32_sh   = (sub_sh > 12'sd25) ? 5'd25 : sub_sh[4:0];
            f32_expf = 8'd0;
        end
        f32_wide = {i_d.sig, 26'd0} >> f32_sh;

        n_q            = '0;
        n_q.dst        = i_d.dst;
        n_q.sign       = i_d.sign;
        n_q.from_float = (i_d.src == FMT_F32) || (i_d.src == FMT_F64);
        n_q.ival       = n_q.from_float ? 32'd0 : i_d.ival;

        // Float to integer: saturate, flush or truncate toward zero.
        if (i_d.is_nan) begin
            n_q.fsat = 1'b0;
        end else if (i_d.is_inf || (i_d.exp >= 12'sd0)) begin
            n_q.fsat = 1'b1;
        end else if (i_d.is_zero || (i_d.exp < -12'sd31)) begin
            n_q.fmag = '0;
        end else begin
            n_q.fmag = int_shifted[30:0];
        end

        // Float32 narrowing; the special encodings bypass rounding.
        n_q.f32_base   = {f32_expf, f32_wide[77:55]};
        n_q.f32_guard  = f32_wide[54];
        n_q.f32_sticky = |f32_wide[53:0];
        if (i_d.is_nan) begin
            n_q.f32_spec      = 1'b1;
            n_q.f32_spec_bits = {i_d.sign, 8'hFF, 1'b1, i_d.sig[50:29]};
        end else if (i_d.is_inf || (i_d.exp >= 12'sd128)) begin
            n_q.f32_spec      = 1'b1;
            n_q.f32_spec_bits = {i_d.sign, 8'hFF, 23'd0};
        end else if (i_d.is_zero) begin
            n_q.f32_spec      = 1'b1;
            n_q.f32_spec_bits = {i_d.sign, 31'd0};
        end

        // Float64 result is exact for every source.
        if (i_d.src == FMT_F64) begin
            n_q.f64_bits = i_d.raw;
        end else if (i_d.is_nan || i_d.is_inf) begin
            n_q.f64_bits = {i_d.sign, 11'h7FF, i_d.sig[51:0]};
        end else if (i_d.is_zero) begin
            n_q.f64_bits = {i_d.sign, 63'd0};
        end else begin
            n_q.f64_bits = {i_d.sign, f64_bexp[10:0], i_d.sig[51:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/pscv_pack.sv =====
`timescale 1ns / 1ps

module pscv_pack (
    input  logic            i_clk,
    input  logic            i_en,
    input  pscv_pkg::t_algn i_d,
    output logic [63:0]     o_q
);
    import pscv_pkg::*;

    logic [63:0] n_q;
    logic [63:0] r_q;
    logic [31:0] fint;
    logic [31:0] int32;
    logic        inc;
    logic [31:0] f32;

    // Apply sign and rounding, then keep the bits of the destination format.
    always_comb begin
        if (i_d.fsat) begin
            fint = i_d.sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (i_d.sign) begin
            fint = 32'd0 - {1'b0, i_d.fmag};
        end else begin
            fint = {1'b0, i_d.fmag};
        end
        int32 = i_d.from_float ? fint : i_d.ival;
        inc   = i_d.f32_guard & (i_d.f32_sticky | i_d.f32_base[0]);
        f32   = i_d.f32_spec ? i_d.f32_spec_bits
                             : {i_d.sign, i_d.f32_base + {30'd0, inc}};
        unique case (i_d.dst)
            FMT_S8:  n_q = {56'd0, int32[31:24]};
            FMT_S16: n_q = {48'd0, int32[31:16]};
            FMT_S24: n_q = {40'd0, int32[31:8]};
            FMT_S32: n_q = {32'd0, int32};
            FMT_F32: n_q = {32'd0, f32};
            FMT_F64: n_q = i_d.f64_bits;
            default: n_q = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/pcm_sample_format_converter.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        sink       i_in_valid / o_in_stall  i_sample_bits (64)
// out       source     o_out_valid / i_out_stall o_converted_bits (64)
// cfg       sink       i_cfg_we                 i_cfg_index (1), i_cfg_data (3)
//
// One sample per clock while the output is not stalled, through four register
// stages (unpack, normalize, align, round and pack).
// Reset clears the stage valid bits and sets both formats to s16.
// A stalled output holds its word; upstream stages keep filling any empty
// slots, so input stalls only once all four stages hold a sample.

module pcm_sample_format_converter (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [63:0]              i_sample_bits,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [63:0]              o_converted_bits,
    input  logic                     i_cfg_we,
    input  pscv_pkg::t_cfg_idx       i_cfg_index,
    input  logic [2:0]               i_cfg_data
);
    import pscv_pkg::*;

    t_fmt       r_src;
    t_fmt       r_dst;
    logic [3:0] r_vld;
    logic [3:0] stage_en;
    t_unpk      s1;
    t_norm      s2;
    t_algn      s3;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= FMT_S16;
            r_dst <= FMT_S16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC: r_src <= i_cfg_data;
                CFG_DST: r_dst <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    assign stage_en[3] = !r_vld[3] || !i_out_stall;
    assign stage_en[2] = !r_vld[2] || stage_en[3];
    assign stage_en[1] = !r_vld[1] || stage_en[2];
    assign stage_en[0] = !r_vld[0] || stage_en[1];
    assign o_in_stall  = !stage_en[0];

    // Valid bits travel alongside the stage data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            if (stage_en[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (stage_en[2]) begin
                r_vld[2] <= r_vld[1];
            end
            if (stage_en[3]) begin
                r_vld[3] <= r_vld[2];
            end
        end
    end

    pscv_unpack u_unpack (
        .i_clk    (i_clk),
        .i_en     (stage_en[0]),
        .i_sample (i_sample_bits),
        .i_src    (r_src),
        .i_dst    (r_dst),
        .o_q      (s1)
    );

    pscv_norm u_norm (
        .i_clk (i_clk),
        .i_en  (stage_en[1]),
        .i_d   (s1),
        .o_q   (s2)
    );

    pscv_align u_align (
        .i_clk (i_clk),
        .i_en  (stage_en[2]),
        .i_d   (s2),
        .o_q   (s3)
    );

    pscv_pack u_pack (
        .i_clk (i_clk),
        .i_en  (stage_en[3]),
        .i_d   (s3),
        .o_q   (o_converted_bits)
    );

    assign o_out_valid = r_vld[3];

endmodule

// ===== rtl/pscv_checker.sv =====
`timescale 1ns / 1ps

module pscv_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic [63:0]         o_converted_bits,
    input  logic                i_cfg_we,
    input  pscv_pkg::t_cfg_idx  i_cfg_index,
    input  logic [2:0]          i_cfg_data
);
    import pscv_pkg::*;

    t_fmt r_dst;

    // Track the destination format from the write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst <= FMT_S16;
        end else if (i_cfg_we && (i_cfg_index == CFG_DST)) begin
            r_dst <= i_cfg_data;
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_converted_bits))
        else $error("stalled output changed");

    // The input stalls only when the output register is occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // 32-bit destinations leave the upper word clear.
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_dst == FMT_S32 || r_dst == FMT_F32)
        |-> o_converted_bits[63:32] == 32'd0)
        else $error("upper word not zero");

    // An unknown destination gives a zero word.
    a_bad_dst_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_dst > FMT_F64) |-> o_converted_bits == 64'd0)
        else $error("unknown destination not zero");

endmodule

bind pcm_sample_format_converter pscv_checker u_pscv_checker (.*);
